// ===== rtl/lru_voice_slot_allocator_macros.svh =====
// Assertion macros shared by the voice slot allocator RTL.
`ifndef LRU_VOICE_SLOT_ALLOCATOR_MACROS_SVH
`define LRU_VOICE_SLOT_ALLOCATOR_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define LVSA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define LVSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lvsa_pkg.sv =====
// Package with types, constants and helpers of the voice slot allocator.
package lvsa_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W     = $clog2(NUM_SLOTS + 1);

  // Command codes of an input item
  localparam logic [1:0] CMD_ALLOC  = 2'd0;
  localparam logic [1:0] CMD_FINISH = 2'd1;
  localparam logic [1:0] CMD_STOP   = 2'd2;

  typedef struct packed {
    logic [1:0] command;
    logic [3:0] finished_slot;
  } lvsa_in_t;

  typedef struct packed {
    logic [3:0] slot_index;
    logic       stolen;
    logic       accepted;
  } lvsa_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN_FREE,
    ST_SCAN_AGE
  } lvsa_state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_STEP,
    OP_GRANT,
    OP_STEAL,
    OP_FINISH,
    OP_STOP,
    OP_REJECT
  } lvsa_op_t;

  typedef struct packed {
    lvsa_op_t op;
  } lvsa_ctrl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       enabled;
    logic       fin_busy;
    logic       cur_busy;
    logic       idx_last;
    logic       idx_at_count;
    logic       age_hit;
  } lvsa_status_t;

  // Low four bits of a slot number, zero-extended for small pools
  function automatic logic [3:0] slot_to_field(input logic [SLOT_W-1:0] s);
    logic [SLOT_W+3:0] w;
    w = {4'b0000, s};
    return w[3:0];
  endfunction

  // Slot number taken from the four-bit finished_slot field
  function automatic logic [SLOT_W-1:0] field_to_slot(input logic [3:0] f);
    logic [SLOT_W+3:0] w;
    w = {{SLOT_W{1'b0}}, f};
    return w[SLOT_W-1:0];
  endfunction

  // True when the four-bit field names a slot of the pool
  function automatic logic field_in_range(input logic [3:0] f);
    return (32'(f) < 32'(NUM_SLOTS));
  endfunction

endpackage

// ===== rtl/lru_voice_slot_allocator.sv =====
// Top level of the voice slot allocator: controller, datapath and checks.
//
//   channel  | ports                          | handshake
//   ---------+--------------------------------+----------------------------------
//   command  | start, busy, item              | taken when start high, busy low
//   result   | result_valid, result           | one-cycle strobe, no back-pressure
//   config   | cfg_wr_en, cfg_wr_data         | written when cfg_wr_en high
//
// Reject and stop-all items end in the dispatch state; allocate and finish items
// then walk over the busy flags or over the age list, one entry a cycle. The
// result strobe is registered and comes in the cycle after the last step.
// Reset (rst, synchronous) frees all slots, empties the age list and sets
// audio_enabled. Busy stays high from the accepting edge until the result.
`include "lru_voice_slot_allocator_macros.svh"
module lru_voice_slot_allocator (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  lvsa_pkg::lvsa_in_t  item,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,
  output logic                result_valid,
  output lvsa_pkg::lvsa_out_t result
);
  import lvsa_pkg::*;

  lvsa_ctrl_t   ctrl;
  lvsa_status_t status;

  // Sequence each item
  lvsa_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .ctrl   (ctrl),
    .busy   (busy)
  );

  // Hold slot state and build results
  lvsa_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .item         (item),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .status       (status),
    .result_valid (result_valid),
    .result       (result)
  );

  // Check: the result arrives only once the walk has ended
  `LVSA_ASSERT_SAME(a_result_idle, result_valid, !busy, "result while busy")
  // Check: an accepted item keeps the block busy in the next cycle
  `LVSA_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !result_valid,
                    "accepted item did not start work")
  // Check: a steal is always a granted allocation
  `LVSA_ASSERT_SAME(a_steal_ok, result_valid && result.stolen, result.accepted,
                    "stolen slot reported as rejected")

endmodule

// ===== rtl/lvsa_ctrl.sv =====
// Controller state machine that sequences the slot and age-list walks.
module lvsa_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  lvsa_pkg::lvsa_status_t status,
  output lvsa_pkg::lvsa_ctrl_t   ctrl,
  output logic                  busy
);
  import lvsa_pkg::*;

  lvsa_state_t state;
  lvsa_state_t state_next;

  // Hold the state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Choose the next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (status.cmd == CMD_ALLOC) begin
          state_next = ST_SCAN_FREE;
        end else if (status.cmd == CMD_FINISH && status.fin_busy) begin
          state_next = ST_SCAN_AGE;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_SCAN_FREE: begin
        if (!status.cur_busy || status.idx_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_SCAN_AGE: begin
        if (status.idx_at_count || status.age_hit) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Drive the datapath operation
  always_comb begin
    ctrl.op = OP_NONE;
    case (state)
      ST_IDLE: begin
        if (start) begin
          ctrl.op = OP_LOAD;
        end
      end
      ST_DISPATCH: begin
        if (status.cmd == CMD_ALLOC) begin
          ctrl.op = OP_NONE;
        end else if (status.cmd == CMD_FINISH && status.fin_busy) begin
          ctrl.op = OP_NONE;
        end else if (status.cmd == CMD_STOP && status.enabled) begin
          ctrl.op = OP_STOP;
        end else begin
          ctrl.op = OP_REJECT;
        end
      end
      ST_SCAN_FREE: begin
        if (!status.cur_busy) begin
          ctrl.op = OP_GRANT;
        end else if (status.idx_last) begin
          ctrl.op = OP_STEAL;
        end else begin
          ctrl.op = OP_STEP;
        end
      end
      ST_SCAN_AGE: begin
        if (status.idx_at_count || status.age_hit) begin
          ctrl.op = OP_FINISH;
        end else begin
          ctrl.op = OP_STEP;
        end
      end
      default: ctrl.op = OP_NONE;
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

// ===== rtl/lvsa_datapath.sv =====
// Datapath: busy flags, age-ordered slot list, walk index and result register.
module lvsa_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  lvsa_pkg::lvsa_ctrl_t   ctrl,
  input  lvsa_pkg::lvsa_in_t     item,
  input  logic                   cfg_wr_en,
  input  logic                   cfg_wr_data,
  output lvsa_pkg::lvsa_status_t status,
  output logic                   result_valid,
  output lvsa_pkg::lvsa_out_t    result
);
  import lvsa_pkg::*;

  logic [1:0]        cmd_q;
  logic [3:0]        fin_q;
  logic [CNT_W-1:0]  idx;
  logic [NUM_SLOTS-1:0] slot_busy;
  logic [SLOT_W-1:0] age_order [NUM_SLOTS];
  logic [CNT_W-1:0]  age_count;
  logic              audio_enabled;

  logic [SLOT_W-1:0] idx_s;
  logic [SLOT_W-1:0] fin_s;
  logic [SLOT_W-1:0] steal_slot;
  logic [CNT_W-1:0]  count_m1;
  logic              terminal;

  assign idx_s      = idx[SLOT_W-1:0];
  assign fin_s      = field_to_slot(fin_q);
  assign steal_slot = (age_count != '0) ? age_order[0] : '0;
  assign count_m1   = age_count - CNT_W'(1);
  assign terminal   = (ctrl.op == OP_GRANT) || (ctrl.op == OP_STEAL) ||
                      (ctrl.op == OP_FINISH) || (ctrl.op == OP_STOP) ||
                      (ctrl.op == OP_REJECT);

  // Report status to the controller
  always_comb begin
    status.cmd          = cmd_q;
    status.enabled      = audio_enabled;
    status.fin_busy     = field_in_range(fin_q) && slot_busy[fin_s];
    status.cur_busy     = slot_busy[idx_s];
    status.idx_last     = (idx == CNT_W'(NUM_SLOTS - 1));
    status.idx_at_count = (idx == age_count);
    status.age_hit      = (age_order[idx_s] == fin_s);
  end

  // Update control state: busy flags, list length, enable and strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_busy     <= '0;
      age_count     <= '0;
      audio_enabled <= 1'b1;
      result_valid  <= 1'b0;
    end else begin
      result_valid <= terminal;
      if (cfg_wr_en) begin
        audio_enabled <= cfg_wr_data;
      end
      case (ctrl.op)
        OP_GRANT: begin
          slot_busy[idx_s] <= 1'b1;
          if (age_count < CNT_W'(NUM_SLOTS)) begin
            age_count <= age_count + CNT_W'(1);
          end
        end
        OP_STEAL: begin
          slot_busy[steal_slot] <= 1'b1;
          if (age_count == '0) begin
            age_count <= CNT_W'(1);
          end
        end
        OP_FINISH: begin
          slot_busy[fin_s] <= 1'b0;
          if (idx < age_count) begin
            age_count <= count_m1;
          end
        end
        OP_STOP: begin
          slot_busy <= '0;
          age_count <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Latch the item, advance the walk, edit the age list, load the result
  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_LOAD: begin
        cmd_q <= item.command;
        fin_q <= item.finished_slot;
        idx   <= '0;
      end
      OP_STEP: begin
        idx <= idx + CNT_W'(1);
      end
      OP_GRANT: begin
        if (age_count < CNT_W'(NUM_SLOTS)) begin
          age_order[age_count[SLOT_W-1:0]] <= idx_s;
        end
        result <= '{slot_index: slot_to_field(idx_s), stolen: 1'b0, accepted: 1'b1};
      end
      OP_STEAL: begin
        // Drop the oldest entry and append the same slot as newest
        if (age_count == '0) begin
          age_order[0] <= '0;
        end else begin
          for (int j = 0; j < NUM_SLOTS; j++) begin
            if (CNT_W'(j) == count_m1) begin
              age_order[j] <= steal_slot;
            end else if (j < NUM_SLOTS - 1) begin
              age_order[j] <= age_order[j + 1];
            end
          end
        end
        result <= '{slot_index: slot_to_field(steal_slot), stolen: 1'b1,
                    accepted: 1'b1};
      end
      OP_FINISH: begin
        // Close the gap left by the finished slot
        if (idx < age_count) begin
          for (int j = 0; j < NUM_SLOTS - 1; j++) begin
            if (CNT_W'(j) >= idx) begin
              age_order[j] <= age_order[j + 1];
            end
          end
        end
        result <= '{slot_index: fin_q, stolen: 1'b0, accepted: 1'b1};
      end
      OP_STOP: begin
        result <= '{slot_index: 4'd0, stolen: 1'b0, accepted: 1'b1};
      end
      OP_REJECT: begin
        result <= '{slot_index: (cmd_q == CMD_FINISH) ? fin_q : 4'd0,
                    stolen: 1'b0, accepted: 1'b0};
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== tb/tb_lru_voice_slot_allocator.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the voice slot allocator: directed and random command items.
module tb_lru_voice_slot_allocator;
  import lvsa_pkg::*;

  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  localparam int SETTLE_CYCLES = 2 * NUM_SLOTS + 8;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  logic      busy;
  lvsa_in_t  item = '0;
  logic      cfg_wr_en = 1'b0;
  logic      cfg_wr_data = 1'b0;
  logic      result_valid;
  lvsa_out_t result;

  // Shadow of the allocator: busy flags, age list (oldest first), audio switch
  bit         slot_taken [NUM_SLOTS];
  logic [3:0] age_list [$];
  bit         audio_on = 1'b1;

  lvsa_out_t  pending_results [$];
  int         mismatches = 0;
  int         idle_pct = 32;
  int         items_sent = 0;
  int         steals = 0;
  int         rejects = 0;
  int         stops = 0;

  lru_voice_slot_allocator uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .result_valid (result_valid),
    .result       (result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Apply one command to the shadow state and return the slot result it grants
  function automatic lvsa_out_t predict_slot_result(input lvsa_in_t cmd_item);
    lvsa_out_t  r;
    int         slot;
    bit         found;
    logic [3:0] fin;
    r = '0;
    slot = 0;
    found = 1'b0;
    fin = cmd_item.finished_slot;
    case (cmd_item.command)
      CMD_ALLOC: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (!slot_taken[i] && !found) begin
            slot = i;
            found = 1'b1;
          end
        end
        // Pool full: evict the slot started longest ago
        if (!found) begin
          r.stolen = 1'b1;
          steals++;
          if (age_list.size() > 0) slot = int'(age_list.pop_front()) % NUM_SLOTS;
          else slot = 0;
        end
        slot_taken[slot] = 1'b1;
        if (age_list.size() < NUM_SLOTS) age_list.push_back(slot[3:0]);
        r.slot_index = slot[3:0];
        r.accepted = 1'b1;
      end
      CMD_FINISH: begin
        r.slot_index = fin;
        if (int'(fin) < NUM_SLOTS && slot_taken[fin]) begin
          slot_taken[fin] = 1'b0;
          for (int i = 0; i < age_list.size(); i++) begin
            if (age_list[i] == fin) begin
              age_list.delete(i);
              break;
            end
          end
          r.accepted = 1'b1;
        end else begin
          rejects++;
        end
      end
      CMD_STOP: begin
        stops++;
        if (audio_on) begin
          foreach (slot_taken[i]) slot_taken[i] = 1'b0;
          age_list.delete();
          r.accepted = 1'b1;
        end else begin
          rejects++;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Send one item; hold start high across back-to-back items, drop it only to idle
  task automatic send_item(input logic [1:0] command, input logic [3:0] slot);
    lvsa_in_t it;
    it.command = command;
    it.finished_slot = slot;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start <= 1'b1;
    item <= it;
    do @(posedge clk); while (busy);
    pending_results.push_back(predict_slot_result(it));
    items_sent++;
  endtask

  // Hold off until every expected result has come back
  task automatic drain;
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_audio_enabled(input bit value);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    audio_on = value;
  endtask

  // Random command; finishes mostly name a slot that is playing
  task automatic send_random(input int alloc_pct, input int finish_pct, input int stop_pct);
    int         r;
    logic [3:0] slot;
    r = $urandom_range(99);
    slot = 4'($urandom_range(15));
    if (r < alloc_pct) begin
      send_item(CMD_ALLOC, slot);
    end else if (r < alloc_pct + finish_pct) begin
      if (age_list.size() > 0 && $urandom_range(3) != 0)
        slot = age_list[$urandom_range(age_list.size() - 1)];
      send_item(CMD_FINISH, slot);
    end else if (r < alloc_pct + finish_pct + stop_pct) begin
      send_item(CMD_STOP, slot);
    end else begin
      send_item(CMD_UNKNOWN, slot);
    end
  endtask

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, want, got);
  endtask

  // Compare each result strobe with the oldest expectation
  always @(posedge clk) begin : check_results
    lvsa_out_t want;
    if (!rst && result_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, slot_index", 0, result.slot_index);
      end else begin
        want = pending_results.pop_front();
        if (result.slot_index !== want.slot_index)
          report_mismatch("slot_index", want.slot_index, result.slot_index);
        if (result.stolen !== want.stolen)
          report_mismatch("stolen", want.stolen, result.stolen);
        if (result.accepted !== want.accepted)
          report_mismatch("accepted", want.accepted, result.accepted);
      end
    end
  end

  // Fill the pool, then steal the oldest voice
  task automatic test_fill_and_steal;
    for (int i = 0; i <= NUM_SLOTS; i++) send_item(CMD_ALLOC, 4'($urandom_range(15)));
  endtask

  // Finish busy and free slots, then refill the lowest hole
  task automatic test_finish;
    send_item(CMD_FINISH, 4'd5);
    send_item(CMD_FINISH, 4'd5);
    send_item(CMD_FINISH, 4'hF);
    send_item(CMD_ALLOC, 4'hF);
  endtask

  // Unknown command, stop-all while disabled and enabled, finish after stop
  task automatic test_stop_and_unknown;
    send_item(CMD_UNKNOWN, 4'hF);
    write_audio_enabled(1'b0);
    send_item(CMD_STOP, 4'hA);
    write_audio_enabled(1'b1);
    send_item(CMD_STOP, 4'h5);
    send_item(CMD_FINISH, 4'd0);
  endtask

  // Mixed traffic over several audio settings, draining between phases
  task automatic test_random_mixed;
    for (int phase = 0; phase < 5; phase++) begin
      write_audio_enabled((phase % 2 == 0) ? 1'b0 : bit'($urandom_range(1)));
      for (int n = 0; n < 80; n++) send_random(45, 40, 8);
    end
  endtask

  // Keep the pool near full so steals dominate; start with no idling
  task automatic test_random_saturated;
    write_audio_enabled(1'b1);
    idle_pct = 0;
    for (int n = 0; n < 230; n++) begin
      if (n == 100) idle_pct = 32;
      send_random(62, 33, 2);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_fill_and_steal();
    test_finish();
    test_stop_and_unknown();
    test_random_mixed();
    test_random_saturated();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d items: %0d steals, %0d stop-all, %0d rejected finishes or stops.",
             items_sent, steals, stops, rejects);
    $display("Audio switch toggled between phases; %0d mismatches counted.", mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/lvsa_pkg.sv
rtl/lvsa_ctrl.sv
rtl/lvsa_datapath.sv
rtl/lru_voice_slot_allocator.sv
tb/tb_lru_voice_slot_allocator.sv
